### src/lpkm_pkg.sv
`timescale 1ns / 1ps

package lpkm_pkg;

	// Fixed field widths.
	localparam int KEY_W      = 64;
	localparam int IN_VALUE_W = 32;
	localparam int CFG_W      = 4;

	// Reset value of the size register (log2 of slots in use).
	localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

	// Item kinds.
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	// Shift amounts of the key mix.
	localparam int MIX_ADD1 = 10;
	localparam int MIX_XOR1 = 6;
	localparam int MIX_ADD2 = 3;
	localparam int MIX_XOR2 = 11;
	localparam int MIX_ADD3 = 15;

	// Sequencer states.
	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_HASH  = 5'b00100,
		ST_CHECK = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

endpackage

### src/lpkm_ram.sv
`timescale 1ns / 1ps

module lpkm_ram #(
	parameter int WIDTH = 97,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### src/lpkm_hash.sv
`timescale 1ns / 1ps

module lpkm_hash (
	input  logic                       clk,
	input  logic                       load,
	input  logic [lpkm_pkg::KEY_W-1:0] key,
	output logic [31:0]                mix
);

	import lpkm_pkg::*;

	logic [KEY_W-1:0] add1;
	logic [KEY_W-1:0] xor1;
	logic [KEY_W-1:0] h_s1;
	logic [KEY_W-1:0] add2;
	logic [KEY_W-1:0] xor2;

	// First half of the mix: add of the left shift, xor of the arithmetic right shift.
	always_comb begin
		add1 = key + (key << MIX_ADD1);
		xor1 = add1 ^ $unsigned($signed(add1) >>> MIX_XOR1);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			h_s1 <= xor1;
		end
	end

	// Second half; only the low 32 bits of the last add are kept.
	always_comb begin
		add2 = h_s1 + (h_s1 << MIX_ADD2);
		xor2 = add2 ^ $unsigned($signed(add2) >>> MIX_XOR2);
		mix  = xor2[31:0] + (xor2[31:0] << MIX_ADD3);
	end

endmodule

### src/linear_probe_integer_key_map_top.sv
`timescale 1ns / 1ps

// Hash map from 64-bit signed keys to values, open addressing with linear probing.
// Input words (kind, key_in, value_in) are taken on in_valid with in_stall low.
// kind 0 inserts the key or updates its value; kind 1 looks the key up.
// Each input word gives one output word (present, refused, value_out), taken on
// out_valid with out_stall low. A new key is refused once count * 2 + 1 reaches
// the number of slots in use; an existing key is always updated.
// cfg_we writes cfg_wdata to the size register (log2 of slots in use); write it
// only while no word is in flight.
// An item goes through hashing, then P probes, P being the number of slots probed
// (1 up to the number of slots in use), then to the result state and the output
// register; each probe is one read of the slot memory, which has one write port
// and one read port. The next word is accepted only once the previous one sits
// in the output register, so a stalled receiver holds at most one word there plus
// one finished result inside the block while in_stall stays high.
// After reset all SLOTS slots of the memory are cleared, one slot per cycle;
// in_stall stays high during that pass.
module linear_probe_integer_key_map_top #(
	parameter int SLOTS      = 256,
	parameter int VALUE_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lpkm_pkg::CFG_W-1:0]        cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              kind,
	input  logic signed [lpkm_pkg::KEY_W-1:0] key_in,
	input  logic [lpkm_pkg::IN_VALUE_W-1:0]   value_in,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              present,
	output logic                              refused,
	output logic [lpkm_pkg::IN_VALUE_W-1:0]   value_out
);

	import lpkm_pkg::*;

	localparam int IDX_W  = $clog2(SLOTS);
	localparam int CNT_W  = IDX_W + 1;
	localparam int WORD_W = 1 + KEY_W + VALUE_BITS;
	localparam logic [16:0]      SLOTS_17 = 17'(SLOTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	state_t                  state_q;
	logic [CFG_W-1:0]        cfg_q;
	logic [IDX_W-1:0]        clr_q;
	logic [IDX_W-1:0]        count_q;
	logic                    kind_q;
	logic [KEY_W-1:0]        key_q;
	logic [VALUE_BITS-1:0]   val_q;
	logic [IDX_W-1:0]        idx_q;
	logic [IDX_W-1:0]        probe_q;
	logic                    res_present_q;
	logic                    res_refused_q;
	logic [IN_VALUE_W-1:0]   res_value_q;

	logic                    in_fire;
	logic                    out_free;
	logic [31:0]             mix;
	logic [CFG_W-1:0]        lg_eff;
	logic [16:0]             pow;
	logic [CNT_W-1:0]        size_w;
	logic [CNT_W-1:0]        size_m1;
	logic [CNT_W-1:0]        home_full;
	logic [IDX_W-1:0]        home_idx;
	logic [CNT_W-1:0]        next_full;
	logic [IDX_W-1:0]        next_idx;
	logic                    room;

	logic                    ram_we;
	logic [IDX_W-1:0]        ram_waddr;
	logic [WORD_W-1:0]       ram_wdata;
	logic                    ram_re;
	logic [IDX_W-1:0]        ram_raddr;
	logic [WORD_W-1:0]       ram_rdata;

	logic                    rd_valid;
	logic [KEY_W-1:0]        rd_key;
	logic [VALUE_BITS-1:0]   rd_val;
	logic                    hit;
	logic                    empty;
	logic                    last_probe;
	logic                    finish;
	logic                    do_write;

	assign in_stall = (state_q != ST_IDLE);
	assign in_fire  = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;

	// Slots in use: 2^max(cfg, 1), limited to SLOTS.
	always_comb begin
		lg_eff  = (cfg_q == '0) ? CFG_W'(1) : cfg_q;
		pow     = 17'(1) << lg_eff;
		size_w  = CNT_W'((pow > SLOTS_17) ? SLOTS_17 : pow);
		size_m1 = size_w - CNT_W'(1);
		room    = {count_q, 1'b1} < size_w;
	end

	// Home slot and the next slot of the probe, wrapping at the size in use.
	always_comb begin
		home_full = mix[CNT_W-1:0] & size_m1;
		home_idx  = (home_full >= size_w) ? '0 : home_full[IDX_W-1:0];
		next_full = {1'b0, idx_q} + CNT_W'(1);
		next_idx  = (next_full >= size_w) ? '0 : next_full[IDX_W-1:0];
	end

	// Decode of the slot word read back.
	always_comb begin
		rd_valid   = ram_rdata[WORD_W-1];
		rd_key     = ram_rdata[WORD_W-2 -: KEY_W];
		rd_val     = ram_rdata[VALUE_BITS-1:0];
		hit        = rd_valid && (rd_key == key_q);
		empty      = !rd_valid;
		last_probe = ({1'b0, probe_q} == size_m1);
		finish     = hit || empty || last_probe;
		do_write   = (kind_q == KIND_INSERT) && (hit || (empty && room));
	end

	// Memory port control: clearing pass, probe reads, write-back.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = {1'b1, key_q, val_q};
		ram_re    = 1'b0;
		ram_raddr = home_idx;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_HASH: begin
				ram_re = 1'b1;
			end
			ST_CHECK: begin
				if (finish) begin
					ram_we = do_write;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = next_idx;
				end
			end
			default: begin
			end
		endcase
	end

	lpkm_hash u_hash (
		.clk  (clk),
		.load (in_fire),
		.key  (key_in),
		.mix  (mix)
	);

	lpkm_ram #(
		.WIDTH (WORD_W),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			cfg_q     <= CFG_RESET;
			clr_q     <= '0;
			count_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (out_valid && !out_stall && (state_q != ST_DONE)) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (finish) begin
						state_q <= ST_DONE;
						if (do_write && !hit) begin
							count_q <= count_q + IDX_W'(1);
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item, probe and result registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q <= kind;
			key_q  <= key_in;
			val_q  <= VALUE_BITS'(value_in);
		end
		if (state_q == ST_HASH) begin
			idx_q   <= home_idx;
			probe_q <= '0;
		end
		if (state_q == ST_CHECK) begin
			if (finish) begin
				res_present_q <= hit;
				res_refused_q <= (kind_q == KIND_INSERT) && !do_write;
				res_value_q   <= ((kind_q == KIND_LOOKUP) && hit) ?
					IN_VALUE_W'(rd_val) : '0;
			end else begin
				idx_q   <= next_idx;
				probe_q <= probe_q + IDX_W'(1);
			end
		end
		if ((state_q == ST_DONE) && out_free) begin
			present   <= res_present_q;
			refused   <= res_refused_q;
			value_out <= res_value_q;
		end
	end

	// The entry count moves only on a write-back at the end of a probe.
	a_count_only_in_check: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_CHECK) |=> $stable(count_q))
		else $error("entry count changed outside the probe state");

	// A new output word comes only from the result state.
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE))
		else $error("output word raised outside the result state");

	// Lookups never write the slot memory.
	a_lookup_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_CHECK) && ram_we) |-> (kind_q == KIND_INSERT))
		else $error("slot memory written by a lookup");

	// The clearing pass ends on the last slot.
	a_clear_end: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_CLEAR) && (clr_q == LAST_IDX)) |=> (state_q == ST_IDLE))
		else $error("clearing pass did not finish on the last slot");

endmodule

### bench/linear_probe_integer_key_map_top_tb.sv
`timescale 1ns / 1ps

module linear_probe_integer_key_map_top_tb;
	import lpkm_pkg::*;

	localparam int SLOTS        = 256;
	localparam int VALUE_BITS   = 32;
	localparam int LIMIT_CYCLES = 3000000;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_ITEMS  = 140;
	localparam logic [KEY_W-1:0] KEY_MIN = 64'h8000_0000_0000_0000;
	localparam logic [KEY_W-1:0] KEY_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [KEY_W-1:0] KEY_ALL = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic                  kind;
		logic [KEY_W-1:0]      key;
		logic [IN_VALUE_W-1:0] value;
	} request_t;

	typedef struct packed {
		logic                  present;
		logic                  refused;
		logic [IN_VALUE_W-1:0] value;
	} answer_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_W-1:0]      cfg_wdata = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	logic                  kind      = KIND_INSERT;
	logic [KEY_W-1:0]      key_in    = '0;
	logic [IN_VALUE_W-1:0] value_in  = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b1;
	logic                  present;
	logic                  refused;
	logic [IN_VALUE_W-1:0] value_out;

	// Words waiting to be offered, and the answers the map should give back.
	request_t waiting_requests[$];
	answer_t  pending_answers[$];
	logic [KEY_W-1:0] known_keys[$];
	request_t offered;

	// Shadow copy of the map.
	bit                    shadow_used[SLOTS];
	logic [KEY_W-1:0]      shadow_key[SLOTS];
	logic [IN_VALUE_W-1:0] shadow_value[SLOTS];
	int unsigned           shadow_count = 0;
	logic [CFG_W-1:0]      shadow_size_log2 = CFG_RESET;

	int sender_idle_pct   = 33;
	int receiver_idle_pct = 87;
	logic hold_req  = 1'b0;
	logic hold_done = 1'b0;
	int   hold_left = 0;

	int cycle_count   = 0;
	int mismatches    = 0;
	int answers_seen  = 0;
	int inserts_sent  = 0;
	int lookups_sent  = 0;
	int hits_seen     = 0;
	int refusals_seen = 0;
	int full_sweeps   = 0;

	linear_probe_integer_key_map_top #(
		.SLOTS(SLOTS),
		.VALUE_BITS(VALUE_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.key_in(key_in),
		.value_in(value_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.present(present),
		.refused(refused),
		.value_out(value_out)
	);

	always #2 clk = ~clk;

	// One-at-a-time style mix of the key; right shifts keep the sign.
	function automatic logic [31:0] key_home_hash(input logic [KEY_W-1:0] k);
		logic [63:0]        h;
		logic signed [63:0] hs;
		logic [63:0]        t;
		h = k;
		h = h + (h << MIX_ADD1);
		hs = h;
		t = hs >>> MIX_XOR1;
		h = h ^ t;
		h = h + (h << MIX_ADD2);
		hs = h;
		t = hs >>> MIX_XOR2;
		h = h ^ t;
		h = h + (h << MIX_ADD3);
		return h[31:0];
	endfunction

	// Applies one word to the shadow map and returns the answer it gives.
	function automatic answer_t map_apply(input request_t rq);
		answer_t     ans;
		int unsigned lg;
		int unsigned size;
		int unsigned idx;
		int unsigned n;
		bit          hit;
		bit          empty;
		ans = '0;
		hit = 1'b0;
		empty = 1'b0;
		lg = 32'(shadow_size_log2);
		if (lg < 1) begin
			lg = 1;
		end
		if (lg > 16) begin
			lg = 16;
		end
		size = 1 << lg;
		if (size > SLOTS) begin
			size = SLOTS;
		end
		idx = key_home_hash(rq.key) & (size - 1);

		// Linear probe with wrap, at most one sweep of the slots in use.
		for (n = 0; n < size; n++) begin
			if (idx >= size) begin
				idx = 0;
			end
			if (!shadow_used[idx]) begin
				empty = 1'b1;
				break;
			end
			if (shadow_key[idx] == rq.key) begin
				hit = 1'b1;
				break;
			end
			idx++;
		end
		if (!hit && !empty) begin
			full_sweeps++;
		end

		if (rq.kind == KIND_LOOKUP) begin
			if (hit) begin
				ans.value = shadow_value[idx];
			end
		end else if (hit) begin
			shadow_value[idx] = rq.value;
		end else if (empty && (shadow_count * 2 + 1 < size)) begin
			shadow_used[idx] = 1'b1;
			shadow_key[idx] = rq.key;
			shadow_value[idx] = rq.value;
			shadow_count++;
		end else begin
			ans.refused = 1'b1;
		end
		ans.present = hit;
		return ans;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatches++;
		if (mismatches <= 20) begin
			$display("mismatch on answer %0d: %s got %h want %h", answers_seen, what, got,
				want);
		end
	endtask

	// Sender: the accepted word is predicted, then the next one may be offered.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				pending_answers.push_back(map_apply(offered));
				if (offered.kind == KIND_LOOKUP) begin
					lookups_sent++;
				end else begin
					inserts_sent++;
				end
			end
			if (!in_valid || !in_stall) begin
				if (waiting_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					offered = waiting_requests.pop_front();
					kind <= offered.kind;
					key_in <= offered.key;
					value_in <= offered.value;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted here once requested.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// Receiver stall.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < receiver_idle_pct);
		end
	end

	// Receiver check: each accepted word against the oldest expected answer.
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && out_valid && !out_stall) begin
			answers_seen++;
			if (present) begin
				hits_seen++;
			end
			if (refused) begin
				refusals_seen++;
			end
			if (pending_answers.size() == 0) begin
				report_mismatch("word with no answer expected", value_out, 32'd0);
			end else begin
				want = pending_answers.pop_front();
				if (present !== want.present) begin
					report_mismatch("present", 32'(present), 32'(want.present));
				end
				if (refused !== want.refused) begin
					report_mismatch("refused", 32'(refused), 32'(want.refused));
				end
				if (value_out !== want.value) begin
					report_mismatch("value_out", value_out, want.value);
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d answers outstanding", cycle_count,
				pending_answers.size());
			$display("linear_probe_integer_key_map_top_tb NOT OK");
			$finish;
		end
	end

	task automatic queue_item(input logic k, input logic [KEY_W-1:0] key,
		input logic [IN_VALUE_W-1:0] value);
		request_t rq;
		rq.kind = k;
		rq.key = key;
		rq.value = value;
		waiting_requests.push_back(rq);
	endtask

	// Keys mix reuse of earlier keys, corner keys and fresh random keys.
	function automatic logic [KEY_W-1:0] pick_key();
		int unsigned      r;
		logic [KEY_W-1:0] k;
		r = $urandom_range(99);
		if (r < 45 && known_keys.size() != 0) begin
			k = known_keys[$urandom_range(known_keys.size() - 1)];
		end else if (r < 55) begin
			case ($urandom_range(4))
				0: k = '0;
				1: k = KEY_ALL;
				2: k = KEY_MIN;
				3: k = KEY_MAX;
				default: k = KEY_W'($urandom_range(15));
			endcase
		end else begin
			k = {$urandom, $urandom};
			known_keys.push_back(k);
		end
		return k;
	endfunction

	task automatic queue_random_item();
		logic [IN_VALUE_W-1:0] v;
		case ($urandom_range(9))
			0: v = '0;
			1: v = '1;
			default: v = $urandom;
		endcase
		queue_item($urandom_range(1) ? KIND_LOOKUP : KIND_INSERT, pick_key(), v);
	endtask

	// The size register is only written with nothing in flight.
	task automatic write_size(input logic [CFG_W-1:0] lg);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= lg;
		shadow_size_log2 = lg;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (waiting_requests.size() != 0 || in_valid || pending_answers.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int unsigned phase_sizes[12];
		int p;
		phase_sizes = '{8, 3, 0, 6, 15, 1, 4, 8, 8, 2, 7, 15};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		// The slot memory is cleared after reset; wait for it to take words.
		do begin
			@(negedge clk);
		end while (in_stall);

		// Register below range acts as two slots: one key fits, a second is refused.
		write_size(4'd0);
		queue_item(KIND_INSERT, '0, 32'hFFFF_FFFF);
		queue_item(KIND_INSERT, KEY_ALL, 32'd1);
		queue_item(KIND_LOOKUP, '0, 32'd0);
		queue_item(KIND_LOOKUP, KEY_ALL, 32'hFFFF_FFFF);
		queue_item(KIND_INSERT, '0, 32'd0);
		queue_item(KIND_LOOKUP, '0, 32'd0);
		wait_drained();

		// Four slots: key 1 lands next to key 0, then the half-full test refuses.
		write_size(4'd2);
		queue_item(KIND_INSERT, 64'd1, 32'h1234_5678);
		queue_item(KIND_INSERT, 64'd2, 32'h0000_0002);
		queue_item(KIND_LOOKUP, 64'd1, 32'd0);
		wait_drained();

		// Shrink to two full slots: absent keys sweep the whole table.
		write_size(4'd1);
		queue_item(KIND_LOOKUP, 64'd5, 32'd0);
		queue_item(KIND_INSERT, 64'd5, 32'd7);
		queue_item(KIND_INSERT, 64'd1, 32'hDEAD_BEEF);
		queue_item(KIND_LOOKUP, 64'd1, 32'd0);
		wait_drained();

		// Register above range acts as the full table; extreme keys and values.
		write_size(4'd15);
		queue_item(KIND_INSERT, KEY_MIN, 32'hA5A5_A5A5);
		queue_item(KIND_INSERT, KEY_MAX, 32'h5A5A_5A5A);
		queue_item(KIND_INSERT, KEY_ALL, 32'h8000_0000);
		queue_item(KIND_LOOKUP, KEY_MIN, 32'hFFFF_FFFF);
		queue_item(KIND_LOOKUP, KEY_MAX, 32'd0);
		queue_item(KIND_LOOKUP, KEY_ALL, 32'd0);
		queue_item(KIND_LOOKUP, '0, 32'd0);
		queue_item(KIND_LOOKUP, 64'd1, 32'd0);
		queue_item(KIND_INSERT, KEY_MIN, 32'd0);
		wait_drained();

		// Random phases, each at its own table size, idling pattern by thirds.
		for (p = 0; p < 12; p++) begin
			if (p == 4) begin
				sender_idle_pct = 87;
				receiver_idle_pct = 33;
			end else if (p == 8) begin
				sender_idle_pct = 0;
				receiver_idle_pct = 0;
				@(posedge clk);
				hold_req <= 1'b1;
			end
			write_size(CFG_W'(phase_sizes[p]));
			repeat (PHASE_ITEMS) queue_random_item();
			wait_drained();
		end

		repeat (300) @(posedge clk);
		$display("sent %0d inserts and %0d lookups over sizes 2 to 256; %0d entries held",
			inserts_sent, lookups_sent, shadow_count);
		$display("answers %0d: %0d hits, %0d refused inserts, %0d full sweeps", answers_seen,
			hits_seen, refusals_seen, full_sweeps);
		if (mismatches == 0) begin
			$display("linear_probe_integer_key_map_top_tb OK");
		end else begin
			$display("linear_probe_integer_key_map_top_tb NOT OK");
		end
		$finish;
	end

endmodule
